[design/windowed_velocity_averager_macros.svh]
// assertion macros for the windowed velocity averager
// used by modules that assert; expects clk and arst_n in scope
`ifndef WINDOWED_VELOCITY_AVERAGER_MACROS_SVH
`define WINDOWED_VELOCITY_AVERAGER_MACROS_SVH

// same-cycle implication, checked out of reset
`define WVA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define WVA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/wva_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the windowed velocity averager
// no dependencies
package wva_pkg;

	// fixed-point constants
	localparam int        US_W         = 20;
	localparam logic [US_W-1:0] US_PER_S = 20'd1000000;
	localparam int        MAG_W        = 33;
	localparam int        NUM_W        = MAG_W + US_W;
	localparam int        WIN_W        = 22;
	localparam logic [WIN_W-1:0] WINDOW_RESET = 22'd100000;
	localparam int        SMP_W        = 128;

	// divide lane operation
	typedef enum logic [0:0] {
		OP_PAIR = 1'b0,
		OP_MEAN = 1'b1
	} lane_op_t;

	// control from the sequencer to the divide lanes
	typedef struct packed {
		logic     start;
		lane_op_t op;
		logic     clr;
	} lane_ctrl_t;

	// lane state
	typedef enum logic [4:0] {
		L_IDLE = 5'b00001,
		L_MUL  = 5'b00010,
		L_CHK  = 5'b00100,
		L_DIV  = 5'b01000,
		L_FIN  = 5'b10000
	} lane_state_t;

	// sequencer state
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_READ  = 7'b0000010,
		S_EVAL  = 7'b0000100,
		S_PAIR  = 7'b0001000,
		S_MEAN  = 7'b0010000,
		S_MWAIT = 7'b0100000,
		S_DONE  = 7'b1000000
	} seq_state_t;

endpackage

[design/wva_ram.sv]
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module wva_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/wva_div_lane.sv]
`timescale 1ns / 1ps
// one axis: pair velocity by multiply and bit-serial divide, running sum, mean
// depends on wva_pkg
module wva_div_lane import wva_pkg::*; #(
	parameter int RING_DEPTH = 16,
	localparam int CNT_W = $clog2(RING_DEPTH)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lane_ctrl_t              ctrl,
	input  logic signed [31:0]      newer,
	input  logic signed [31:0]      older,
	input  logic [31:0]             dt,
	input  logic [CNT_W-1:0]        pair_cnt,
	output logic                    done,
	output logic signed [31:0]      result
);

	localparam int ACC_W = 32 + CNT_W;

	lane_state_t              state_q;
	lane_op_t                 op_q;
	logic                     neg_q;
	logic                     ovf_q;
	logic [31:0]              div_q;
	logic [MAG_W-1:0]         mag_q;
	logic [NUM_W-1:0]         num_q;
	logic [31:0]              rem_q;
	logic [31:0]              quo_q;
	logic [4:0]               step_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [31:0]       res_q;
	logic                     done_q;

	logic signed [MAG_W-1:0]  diff;
	logic [MAG_W-1:0]         diff_mag;
	logic [ACC_W-1:0]         acc_mag;
	logic [32:0]              trial;
	logic [32:0]              trial_sub;
	logic                     trial_ge;
	logic                     hi_ge;
	logic signed [31:0]       sat;

	// signed difference and magnitudes for the two operations
	always_comb begin
		diff     = $signed({newer[31], newer}) - $signed({older[31], older});
		diff_mag = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
		acc_mag  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	end

	// restoring divide step and overflow check on the upper numerator bits
	always_comb begin
		trial     = {rem_q, quo_q[31]};
		trial_sub = trial - {1'b0, div_q};
		trial_ge  = trial >= {1'b0, div_q};
		hi_ge     = {11'd0, num_q[NUM_W-1:32]} >= div_q;
	end

	// sign and clamp of the quotient
	always_comb begin
		if (!neg_q) begin
			sat = (ovf_q || quo_q[31]) ? 32'sh7FFFFFFF : $signed(quo_q);
		end else begin
			sat = (ovf_q || (quo_q[31] && (quo_q[30:0] != 31'd0))) ?
				32'sh80000000 : $signed(-quo_q);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q  <= 1'b0;
			step_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				L_IDLE: begin
					if (ctrl.start) begin
						state_q <= (ctrl.op == OP_PAIR) ? L_MUL : L_CHK;
					end
				end
				L_MUL: begin
					state_q <= L_CHK;
				end
				// an overflowed quotient still runs every step so the three lanes stay in step
				L_CHK: begin
					step_q  <= '0;
					state_q <= L_DIV;
				end
				L_DIV: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd31) begin
						state_q <= L_FIN;
					end
				end
				L_FIN: begin
					done_q  <= 1'b1;
					state_q <= L_IDLE;
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else begin
			if (ctrl.clr) begin
				acc_q <= '0;
			end else if (state_q == L_FIN && op_q == OP_PAIR) begin
				acc_q <= acc_q + {{CNT_W{sat[31]}}, sat};
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			L_IDLE: begin
				if (ctrl.start) begin
					op_q <= ctrl.op;
					if (ctrl.op == OP_PAIR) begin
						neg_q <= diff[MAG_W-1];
						mag_q <= diff_mag;
						div_q <= dt;
					end else begin
						neg_q <= acc_q[ACC_W-1];
						num_q <= NUM_W'(acc_mag);
						div_q <= 32'(pair_cnt);
					end
				end
			end
			L_MUL: begin
				num_q <= mag_q * US_PER_S;
			end
			L_CHK: begin
				ovf_q <= hi_ge;
				rem_q <= {11'd0, num_q[NUM_W-1:32]};
				quo_q <= num_q[31:0];
			end
			L_DIV: begin
				rem_q <= trial_ge ? trial_sub[31:0] : trial[31:0];
				quo_q <= {quo_q[30:0], trial_ge};
			end
			L_FIN: begin
				if (op_q == OP_MEAN) begin
					res_q <= sat;
				end
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

[design/windowed_velocity_averager.sv]
`timescale 1ns / 1ps
// walk: the first sample after restart has no pair to walk; each contributing pair takes
// a ram read, a multiply and a 32-step serial divide in three axis lanes,
// a skipped pair only the ram read and its tests, the final mean runs through the same dividers
// flow: one item in flight, the next beat accepted only once the result is in the output
// reg and the walk is back in idle, with up to 15 pairs to walk per item
// reset: window 100000 us, history empty, no result pending; ring ram is not cleared
`include "windowed_velocity_averager_macros.svh"
// top level: sample ring in ram, backward walk sequencer, three divide lanes
// depends on wva_pkg, wva_ram, wva_div_lane
module windowed_velocity_averager import wva_pkg::*; #(
	parameter int RING_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [WIN_W-1:0]    cfg_wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	input  logic [31:0]         timestamp_us,
	input  logic                restart,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  vel_x,
	output logic signed [31:0]  vel_y,
	output logic signed [31:0]  vel_z,
	output logic                valid_res
);

	localparam int SLOT_W = $clog2(RING_DEPTH);
	localparam int FILL_W = $clog2(RING_DEPTH + 1);
	localparam int CNT_W  = $clog2(RING_DEPTH);

	seq_state_t          state_q;
	logic [WIN_W-1:0]    win_q;
	logic [SLOT_W-1:0]   newest_q;
	logic [SLOT_W-1:0]   cur_slot_q;
	logic [FILL_W-1:0]   filled_q;
	logic [FILL_W-1:0]   rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic signed [31:0]  cur_x_q, cur_y_q, cur_z_q;
	logic [31:0]         cur_t_q;
	logic [31:0]         tn_q;
	logic                out_valid_q;
	logic signed [31:0]  vel_x_q, vel_y_q, vel_z_q;
	logic                valid_res_q;

	logic                accept;
	logic [SLOT_W-1:0]   new_slot;
	logic [FILL_W-1:0]   filled_new;
	logic [SLOT_W-1:0]   prev_slot;
	logic [SMP_W-1:0]    rdata;
	logic signed [31:0]  px, py, pz;
	logic [31:0]         pt;
	logic                skip;
	logic signed [32:0]  age;
	logic                too_old;
	lane_ctrl_t          lctrl;
	logic                done_x, done_y, done_z;
	logic signed [31:0]  mean_x, mean_y, mean_z;
	logic                out_free;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// slot of the new sample and fill level after it
	always_comb begin
		if (restart) begin
			new_slot   = '0;
			filled_new = FILL_W'(1);
		end else begin
			new_slot   = (newest_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : newest_q + SLOT_W'(1);
			filled_new = (filled_q == FILL_W'(RING_DEPTH)) ? filled_q : filled_q + FILL_W'(1);
		end
		prev_slot = (cur_slot_q == '0) ? SLOT_W'(RING_DEPTH - 1) : cur_slot_q - SLOT_W'(1);
	end

	// sample ring
	wva_ram #(
		.WIDTH (SMP_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (accept),
		.waddr (new_slot),
		.wdata ({pos_x, pos_y, pos_z, timestamp_us}),
		.re    (state_q == S_READ),
		.raddr (prev_slot),
		.rdata (rdata)
	);

	// older sample of the current pair, skip and window tests
	always_comb begin
		px      = rdata[127:96];
		py      = rdata[95:64];
		pz      = rdata[63:32];
		pt      = rdata[31:0];
		skip    = cur_t_q <= pt;
		age     = $signed({1'b0, tn_q}) - $signed({1'b0, pt});
		too_old = age > $signed({11'd0, win_q});
	end

	// lane control
	always_comb begin
		lctrl.clr   = accept;
		lctrl.start = 1'b0;
		lctrl.op    = OP_PAIR;
		if (state_q == S_EVAL && !skip && !too_old) begin
			lctrl.start = 1'b1;
		end else if (state_q == S_MEAN && cnt_q != '0) begin
			lctrl.start = 1'b1;
			lctrl.op    = OP_MEAN;
		end
	end

	// axis lanes
	wva_div_lane #(.RING_DEPTH(RING_DEPTH)) u_lane_x (
		.clk (clk), .arst_n (arst_n), .ctrl (lctrl),
		.newer (cur_x_q), .older (px), .dt (cur_t_q - pt), .pair_cnt (cnt_q),
		.done (done_x), .result (mean_x)
	);
	wva_div_lane #(.RING_DEPTH(RING_DEPTH)) u_lane_y (
		.clk (clk), .arst_n (arst_n), .ctrl (lctrl),
		.newer (cur_y_q), .older (py), .dt (cur_t_q - pt), .pair_cnt (cnt_q),
		.done (done_y), .result (mean_y)
	);
	wva_div_lane #(.RING_DEPTH(RING_DEPTH)) u_lane_z (
		.clk (clk), .arst_n (arst_n), .ctrl (lctrl),
		.newer (cur_z_q), .older (pz), .dt (cur_t_q - pt), .pair_cnt (cnt_q),
		.done (done_z), .result (mean_z)
	);

	// window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WINDOW_RESET;
		end else if (cfg_wr_en) begin
			win_q <= cfg_wr_data;
		end
	end

	// walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			newest_q   <= SLOT_W'(RING_DEPTH - 1);
			filled_q   <= '0;
			rem_q      <= '0;
			cnt_q      <= '0;
			cur_slot_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						newest_q   <= new_slot;
						cur_slot_q <= new_slot;
						filled_q   <= filled_new;
						rem_q      <= filled_new - FILL_W'(1);
						cnt_q      <= '0;
						state_q    <= (filled_new == FILL_W'(1)) ? S_MEAN : S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (skip) begin
						cur_slot_q <= prev_slot;
						rem_q      <= rem_q - FILL_W'(1);
						state_q    <= (rem_q == FILL_W'(1)) ? S_MEAN : S_READ;
					end else if (too_old) begin
						state_q <= S_MEAN;
					end else begin
						cur_slot_q <= prev_slot;
						rem_q      <= rem_q - FILL_W'(1);
						cnt_q      <= cnt_q + CNT_W'(1);
						state_q    <= S_PAIR;
					end
				end
				S_PAIR: begin
					if (done_x) begin
						state_q <= (rem_q == '0) ? S_MEAN : S_READ;
					end
				end
				S_MEAN: begin
					state_q <= (cnt_q == '0) ? S_DONE : S_MWAIT;
				end
				S_MWAIT: begin
					if (done_x) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// newer sample of the current pair
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_x_q <= pos_x;
			cur_y_q <= pos_y;
			cur_z_q <= pos_z;
			cur_t_q <= timestamp_us;
			tn_q    <= timestamp_us;
		end else if (state_q == S_EVAL) begin
			cur_x_q <= px;
			cur_y_q <= py;
			cur_z_q <= pz;
			cur_t_q <= pt;
		end
	end

	// output register, result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			valid_res_q <= (cnt_q != '0);
			vel_x_q     <= (cnt_q != '0) ? mean_x : 32'sd0;
			vel_y_q     <= (cnt_q != '0) ? mean_y : 32'sd0;
			vel_z_q     <= (cnt_q != '0) ? mean_z : 32'sd0;
		end
	end

	assign out_valid = out_valid_q;
	assign vel_x     = vel_x_q;
	assign vel_y     = vel_y_q;
	assign vel_z     = vel_z_q;
	assign valid_res = valid_res_q;

	// checks
	`WVA_ASSERT_IMP(a_lane_done_when_waiting, done_x || done_y || done_z,
		(done_x && done_y && done_z) && (state_q == S_PAIR || state_q == S_MWAIT),
		"lane finished outside a wait state or lanes out of step")
	`WVA_ASSERT_NXT(a_accept_starts_walk, accept, state_q != S_IDLE,
		"accepted sample did not start a walk")
	`WVA_ASSERT_IMP(a_rem_below_fill, state_q != S_IDLE, rem_q < filled_q,
		"pairs left exceed stored samples")
	`WVA_ASSERT_IMP(a_zero_when_no_pair, out_valid_q && !valid_res_q,
		vel_x_q == 32'sd0 && vel_y_q == 32'sd0 && vel_z_q == 32'sd0,
		"nonzero velocity without a contributing pair")

endmodule

[tb/windowed_velocity_averager_test.sv]
`timescale 1ns / 1ps
// self-checking bench for the windowed velocity averager: directed table, then random tracks
// depends on wva_pkg and the windowed_velocity_averager design files
module windowed_velocity_averager_test;
	import wva_pkg::*;

	localparam int RING_DEPTH = 16;
	localparam longint MICROS_PER_SEC = 64'sd1000000;
	localparam longint RATE_MAX = (64'sd1 <<< 31) - 1;
	localparam longint RATE_MIN = -(64'sd1 <<< 31);
	localparam logic [31:0] VAL_MIN = 32'h8000_0000;
	localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 800;
	localparam int ITEMS_PER_PHASE = 290;
	localparam logic [WIN_W-1:0] PHASE_WINDOWS [5] = '{22'd1, 22'd4000000, 22'h3FFFFF,
		22'd0, WINDOW_RESET};

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] t;
		logic        restart;
	} sample_t;

	typedef struct packed {
		logic [31:0] vx;
		logic [31:0] vy;
		logic [31:0] vz;
		logic        valid;
	} velocity_t;

	// pred rows go through the predictor, fixed rows carry their own answer,
	// window rows write the register with the value held in t
	typedef enum logic [1:0] {
		ROW_PRED,
		ROW_FIXED,
		ROW_WINDOW
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] t;
		logic        restart;
		logic [31:0] vx;
		logic [31:0] vy;
		logic [31:0] vz;
		logic        vr;
	} row_t;

	localparam int PLAN_LEN = 26;
	localparam row_t PLAN [PLAN_LEN] = '{
		// first sample after reset, then one plain pair
		'{ROW_FIXED, 0, 0, 0, 1000, 0, 0, 0, 0, 0},
		'{ROW_FIXED, 256, -256, 0, 2000, 0, 256000, -256000, 0, 1},
		// repeated timestamp, then a timestamp that goes back
		'{ROW_PRED, 512, 0, -512, 2000, 0, 0, 0, 0, 0},
		'{ROW_PRED, 768, 5, 7, 1500, 0, 0, 0, 0, 0},
		// full-scale swing over one microsecond clamps both ways
		'{ROW_FIXED, VAL_MIN, VAL_MAX, VAL_MIN, 0, 1, 0, 0, 0, 0},
		'{ROW_FIXED, VAL_MAX, VAL_MIN, VAL_MIN, 1, 0, VAL_MAX, VAL_MIN, 0, 1},
		// largest timestamp, then a pair with no positive step
		'{ROW_FIXED, VAL_MAX, VAL_MAX, VAL_MAX, 32'hFFFF_FFFF, 1, 0, 0, 0, 0},
		'{ROW_FIXED, VAL_MIN, VAL_MIN, VAL_MIN, 0, 0, 0, 0, 0, 0},
		// older sample just past the window edge
		'{ROW_FIXED, 100, 200, 300, 5000, 1, 0, 0, 0, 0},
		'{ROW_FIXED, 356, 200, 300, 105001, 0, 0, 0, 0, 0},
		'{ROW_PRED, 612, -50, 300, 105002, 0, 0, 0, 0, 0},
		// older sample later than the newest one still counts
		'{ROW_FIXED, 0, 0, 0, 10000, 1, 0, 0, 0, 0},
		'{ROW_PRED, 1000, -1000, 77, 11000, 0, 0, 0, 0, 0},
		'{ROW_PRED, -1000, 1000, -77, 9000, 0, 0, 0, 0, 0},
		// zero window lets nothing through
		'{ROW_WINDOW, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_FIXED, 0, 0, 0, 100, 1, 0, 0, 0, 0},
		'{ROW_FIXED, 10, 20, 30, 200, 0, 0, 0, 0, 0},
		'{ROW_FIXED, 40, 50, 60, 200, 0, 0, 0, 0, 0},
		// widest window, age exactly at and just past it
		'{ROW_WINDOW, 0, 0, 0, 32'h003F_FFFF, 0, 0, 0, 0, 0},
		'{ROW_FIXED, 0, 0, 0, 0, 1, 0, 0, 0, 0},
		'{ROW_PRED, VAL_MAX, -4096, 4096, 4194303, 0, 0, 0, 0, 0},
		'{ROW_PRED, 0, 4096, -4096, 4194305, 0, 0, 0, 0, 0},
		// one-microsecond window
		'{ROW_WINDOW, 0, 0, 0, 1, 0, 0, 0, 0, 0},
		'{ROW_FIXED, 0, 0, 0, 50, 1, 0, 0, 0, 0},
		'{ROW_FIXED, 256, 0, 0, 51, 0, 256000000, 0, 0, 1},
		'{ROW_PRED, -256, -9, 9, 52, 0, 0, 0, 0, 0}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [WIN_W-1:0]    cfg_wr_data;
	logic                in_valid;
	logic                in_ready;
	logic signed [31:0]  pos_x;
	logic signed [31:0]  pos_y;
	logic signed [31:0]  pos_z;
	logic [31:0]         timestamp_us;
	logic                restart;
	logic                out_valid;
	logic                out_ready;
	logic signed [31:0]  vel_x;
	logic signed [31:0]  vel_y;
	logic signed [31:0]  vel_z;
	logic                valid_res;

	// predictor copy of the sample history and window
	logic [31:0]      hist_x [RING_DEPTH];
	logic [31:0]      hist_y [RING_DEPTH];
	logic [31:0]      hist_z [RING_DEPTH];
	logic [31:0]      hist_t [RING_DEPTH];
	int               head_slot;
	int               hist_len;
	logic [WIN_W-1:0] cur_window;

	velocity_t pending_velocities [$];
	int        fault_count = 0;
	int        idle_cycles = 0;
	int        send_quiet = 0;
	int        recv_quiet = 0;

	windowed_velocity_averager #(
		.RING_DEPTH(RING_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.timestamp_us(timestamp_us),
		.restart(restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.vel_x(vel_x),
		.vel_y(vel_y),
		.vel_z(vel_z),
		.valid_res(valid_res)
	);

	always #4 clk = ~clk;

	// finite-difference rate of one axis, clamped to 32 bits
	function automatic longint pair_rate(logic [31:0] newer, logic [31:0] older,
		logic [31:0] dt);
		longint rate;
		rate = (longint'($signed(newer)) - longint'($signed(older))) * MICROS_PER_SEC
			/ longint'(dt);
		if (rate > RATE_MAX)
			rate = RATE_MAX;
		if (rate < RATE_MIN)
			rate = RATE_MIN;
		return rate;
	endfunction

	// store one sample and average the pair rates inside the window
	function automatic velocity_t average_velocity(sample_t s);
		longint    sum_x, sum_y, sum_z;
		int        pairs, cur, prv;
		logic [31:0] dt;
		velocity_t v;
		sum_x = 0;
		sum_y = 0;
		sum_z = 0;
		pairs = 0;
		if (s.restart) begin
			hist_len = 0;
			head_slot = RING_DEPTH - 1;
		end
		head_slot = (head_slot + 1) % RING_DEPTH;
		hist_x[head_slot] = s.x;
		hist_y[head_slot] = s.y;
		hist_z[head_slot] = s.z;
		hist_t[head_slot] = s.t;
		if (hist_len < RING_DEPTH)
			hist_len++;
		// walk from the newest sample toward older ones
		cur = head_slot;
		for (int i = 0; i + 1 < hist_len; i++) begin
			prv = (cur == 0) ? RING_DEPTH - 1 : cur - 1;
			if (hist_t[cur] > hist_t[prv]) begin
				if (longint'(hist_t[head_slot]) - longint'(hist_t[prv]) > longint'(cur_window))
					break;
				dt = hist_t[cur] - hist_t[prv];
				sum_x += pair_rate(hist_x[cur], hist_x[prv], dt);
				sum_y += pair_rate(hist_y[cur], hist_y[prv], dt);
				sum_z += pair_rate(hist_z[cur], hist_z[prv], dt);
				pairs++;
			end
			cur = prv;
		end
		if (pairs == 0) begin
			v = '0;
		end else begin
			v.vx = 32'(sum_x / pairs);
			v.vy = 32'(sum_y / pairs);
			v.vz = 32'(sum_z / pairs);
			v.valid = 1'b1;
		end
		return v;
	endfunction

	// wait before a beat: mostly a random gap, with runs of back-to-back beats
	function automatic int draw_wait(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			quiet = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 8);
	endfunction

	// drive one sample beat and queue its expected velocity
	task automatic send_sample(sample_t s, bit typed, velocity_t typed_want);
		int        gap;
		velocity_t predicted;
		gap = draw_wait(send_quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= s.x;
		pos_y <= s.y;
		pos_z <= s.z;
		timestamp_us <= s.t;
		restart <= s.restart;
		do @(posedge clk); while (!in_ready);
		predicted = average_velocity(s);
		pending_velocities.push_back(typed ? typed_want : predicted);
		@(negedge clk);
	endtask

	// hold off new samples until every velocity is back
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_velocities.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_window(logic [WIN_W-1:0] w);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= w;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cur_window = w;
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
			fault_count++;
		end
	endtask

	// stimulus
	initial begin
		sample_t          s;
		velocity_t        want;
		logic [WIN_W-1:0] w;
		logic [31:0]      t_now;
		logic [31:0]      span;
		logic [31:0]      pos [3];
		int               pick;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		timestamp_us = '0;
		restart = 1'b0;
		out_ready = 1'b0;
		cur_window = WINDOW_RESET;
		head_slot = RING_DEPTH - 1;
		hist_len = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int i = 0; i < PLAN_LEN; i++) begin
			s = '{PLAN[i].x, PLAN[i].y, PLAN[i].z, PLAN[i].t, PLAN[i].restart};
			want = '{PLAN[i].vx, PLAN[i].vy, PLAN[i].vz, PLAN[i].vr};
			case (PLAN[i].kind)
				ROW_WINDOW: set_window(PLAN[i].t[WIN_W-1:0]);
				ROW_FIXED:  send_sample(s, 1'b1, want);
				default:    send_sample(s, 1'b0, want);
			endcase
		end

		// random tracks, one window setting per phase
		t_now = 32'd1000000;
		pos = '{32'd0, 32'd0, 32'd0};
		for (int p = 0; p < 5; p++) begin
			w = (p == 3) ? WIN_W'($urandom_range(1, 4000000)) : PHASE_WINDOWS[p];
			set_window(w);
			span = w / 4 + 1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// mostly steady forward steps inside the window
				pick = $urandom_range(0, 99);
				if (pick < 78)
					t_now = t_now + $urandom_range(1, span);
				else if (pick < 88)
					t_now = t_now + $urandom_range(1, 2 * w + 2);
				else if (pick < 95)
					t_now = t_now - $urandom_range(0, span);
				else
					t_now = $urandom;
				// small motion with the odd jump anywhere in range
				for (int a = 0; a < 3; a++) begin
					if ($urandom_range(0, 19) == 0)
						pos[a] = $urandom;
					else
						pos[a] = pos[a] + $urandom_range(0, 4000) - 2000;
				end
				s = '{pos[0], pos[1], pos[2], t_now, ($urandom_range(0, 39) == 0)};
				send_sample(s, 1'b0, '0);
				if ($urandom_range(0, 149) == 0)
					wait_idle();
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// result side: random back-pressure, compare each beat with the oldest expectation
	initial begin : result_sink
		velocity_t want;
		int        stall;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = draw_wait(recv_quiet);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_velocities.size() == 0) begin
				$error("velocity beat with no sample pending");
				fault_count++;
			end else begin
				want = pending_velocities.pop_front();
				check_field("vel_x", want.vx, vel_x);
				check_field("vel_y", want.vy, vel_y);
				check_field("vel_z", want.vz, vel_z);
				check_field("valid_res", 32'(want.valid), 32'(valid_res));
			end
			@(negedge clk);
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule

[sim.f]
+incdir+design
design/wva_pkg.sv
design/wva_ram.sv
design/wva_div_lane.sv
design/windowed_velocity_averager.sv
tb/windowed_velocity_averager_test.sv
